// ----- rtl/core/hmt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hmt_pkg;

    localparam int NUM_SLOTS     = 4;
    localparam int NUM_DETECTORS = 5;
    localparam int COUNT_BITS    = 9;

    localparam int DET_W     = 3;
    localparam int PID_W     = 32;
    localparam int MOM_W     = 16;
    localparam int MINH_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int PCOUNT_W  = 3;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [PID_W-1:0]      pid_t;
    typedef logic [MINH_W-1:0]     minh_t;
    typedef logic [DET_W-1:0]      det_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

    // detector numbers
    localparam det_t DET_BBC  = 3'd0;
    localparam det_t DET_MUI  = 3'd1;
    localparam det_t DET_MUT  = 3'd2;
    localparam det_t DET_MUPC = 3'd3;
    localparam det_t DET_SVX  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DETECTOR_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABS_ONLY          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MOMENTUM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS_PACKED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_IDS_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_IDS_HIGH = 3'd6;

    function automatic count_t sat_inc(input count_t c);
        return (c == COUNT_MAX) ? c : c + count_t'(1);
    endfunction

    // unsigned magnitude of a two's complement id, most negative maps to 2^31
    function automatic pid_t magnitude(input pid_t v);
        return v[PID_W-1] ? pid_t'(~v + pid_t'(1)) : v;
    endfunction

    function automatic pid_t slot_id(input logic [63:0] ids_low,
                                     input logic [63:0] ids_high,
                                     input int p);
        pid_t id;
        case (p)
            0: id = ids_low[31:0];
            1: id = ids_low[63:32];
            2: id = ids_high[31:0];
            3: id = ids_high[63:32];
            default: id = '0;
        endcase
        return id;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hmt_slot_match.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hmt_slot_match (
    input  wire hmt_pkg::pid_t                      hit_id,
    input  wire                                     abs_only,
    input  wire [63:0]                              ids_low,
    input  wire [63:0]                              ids_high,
    input  wire [hmt_pkg::PCOUNT_W-1:0]             particle_count,
    output logic [hmt_pkg::NUM_SLOTS-1:0]           match
);
    import hmt_pkg::*;

    pid_t hid;
    pid_t sid [NUM_SLOTS];

    assign hid = abs_only ? magnitude(hit_id) : hit_id;

    always_comb begin
        for (int p = 0; p < NUM_SLOTS; p++) begin
            sid[p] = slot_id(ids_low, ids_high, p);
            if (abs_only) begin
                sid[p] = magnitude(sid[p]);
            end
            // slots beyond particle_count are off; a count above the slot total keeps all on
            match[p] = (int'(particle_count) > p) && (sid[p] == hid);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/hit_multiplicity_trigger_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Hit multiplicity trigger. One hit request is taken every cycle unless the input
// is stalled; it lands in an input register, and from there one pass of logic
// updates the per detector totals and per detector/slot counters (all flip-flops)
// and, for a request with end_of_event set, loads the decision into the output
// register. Only a closing request waits on a full, stalled output register; all
// others keep flowing. Configuration writes are taken in any cycle and should be
// made while no event is in flight.
module hit_multiplicity_trigger_top (
    input  wire                             aclk,
    input  wire                             aresetn,

    input  wire                             s_valid,
    output logic                            s_ready,
    input  wire                             s_hit_valid,
    input  wire [hmt_pkg::DET_W-1:0]        s_detector_kind,
    input  wire signed [hmt_pkg::PID_W-1:0] s_particle_code,
    input  wire [hmt_pkg::MOM_W-1:0]        s_hit_momentum,
    input  wire                             s_end_of_event,

    output logic                            m_valid,
    input  wire                             m_ready,
    output logic                            m_triggered,

    input  wire                             cfg_valid,
    output logic                            cfg_ready,
    input  wire [hmt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [hmt_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import hmt_pkg::*;

    // configuration
    logic [NUM_DETECTORS-1:0]        enable_reg;
    logic                            abs_only_reg;
    logic [MOM_W-1:0]                min_mom_reg;
    logic [NUM_DETECTORS*MINH_W-1:0] min_hits_reg;
    logic [PCOUNT_W-1:0]             pcount_reg;
    logic [63:0]                     ids_low_reg;
    logic [63:0]                     ids_high_reg;

    // input register
    logic             in_valid_reg;
    logic             hit_reg;
    det_t             det_reg;
    pid_t             pid_reg;
    logic [MOM_W-1:0] mom_reg;
    logic             eoe_reg;

    // event state
    count_t cnt_reg  [NUM_DETECTORS][NUM_SLOTS];
    count_t cnt_next [NUM_DETECTORS][NUM_SLOTS];
    count_t tot_reg  [NUM_DETECTORS];
    count_t tot_next [NUM_DETECTORS];
    logic   fired_reg;
    logic   fired_next;

    logic out_valid_reg;
    logic trig_reg;
    logic trig_next;

    logic                     proceed;
    logic [NUM_SLOTS-1:0]     match;
    logic                     needs_mom;
    logic                     mom_ok;
    logic [NUM_DETECTORS-1:0] det_hit;
    logic                     any_total;
    logic                     state_busy;
    minh_t                    minh [NUM_DETECTORS];

    assign cfg_ready   = 1'b1;
    assign proceed     = in_valid_reg && (!eoe_reg || !out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || proceed;
    assign m_valid     = out_valid_reg;
    assign m_triggered = trig_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg   <= '0;
            abs_only_reg <= 1'b0;
            min_mom_reg  <= '0;
            min_hits_reg <= '0;
            pcount_reg   <= '0;
            ids_low_reg  <= '0;
            ids_high_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_DETECTOR_ENABLE:   enable_reg   <= cfg_data[NUM_DETECTORS-1:0];
                CFG_ABS_ONLY:          abs_only_reg <= cfg_data[0];
                CFG_MIN_MOMENTUM:      min_mom_reg  <= cfg_data[MOM_W-1:0];
                CFG_MIN_HITS_PACKED:   min_hits_reg <= cfg_data[NUM_DETECTORS*MINH_W-1:0];
                CFG_PARTICLE_COUNT:    pcount_reg   <= cfg_data[PCOUNT_W-1:0];
                CFG_PARTICLE_IDS_LOW:  ids_low_reg  <= cfg_data;
                CFG_PARTICLE_IDS_HIGH: ids_high_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hit_reg <= s_hit_valid;
            det_reg <= s_detector_kind;
            pid_reg <= s_particle_code;
            mom_reg <= s_hit_momentum;
            eoe_reg <= s_end_of_event;
        end
    end

    hmt_slot_match u_match (
        .hit_id         (pid_reg),
        .abs_only       (abs_only_reg),
        .ids_low        (ids_low_reg),
        .ids_high       (ids_high_reg),
        .particle_count (pcount_reg),
        .match          (match)
    );

    always_comb begin
        needs_mom = det_reg inside {DET_MUI, DET_MUT, DET_SVX};
        mom_ok    = !needs_mom || (mom_reg > min_mom_reg);
    end

    always_comb begin
        count_t inc_val;
        logic   inc;
        fired_next = fired_reg;
        any_total  = 1'b0;
        for (int d = 0; d < NUM_DETECTORS; d++) begin
            minh[d]    = min_hits_reg[d*MINH_W +: MINH_W];
            det_hit[d] = hit_reg && (det_reg == det_t'(d)) && enable_reg[d];
            tot_next[d] = det_hit[d] ? sat_inc(tot_reg[d]) : tot_reg[d];
            for (int p = 0; p < NUM_SLOTS; p++) begin
                inc     = det_hit[d] && mom_ok && match[p];
                inc_val = sat_inc(cnt_reg[d][p]);
                cnt_next[d][p] = inc ? inc_val : cnt_reg[d][p];
                if (inc && (inc_val > count_t'(minh[d]))) begin
                    fired_next = 1'b1;
                end
            end
            // any particle mode: total reaching the minimum is enough
            if (enable_reg[d] && (tot_next[d] >= count_t'(minh[d]))) begin
                any_total = 1'b1;
            end
        end
        trig_next = (pcount_reg == '0) ? any_total : fired_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fired_reg <= 1'b0;
            for (int d = 0; d < NUM_DETECTORS; d++) begin
                tot_reg[d] <= '0;
                for (int p = 0; p < NUM_SLOTS; p++) begin
                    cnt_reg[d][p] <= '0;
                end
            end
        end else if (proceed) begin
            fired_reg <= eoe_reg ? 1'b0 : fired_next;
            for (int d = 0; d < NUM_DETECTORS; d++) begin
                tot_reg[d] <= eoe_reg ? '0 : tot_next[d];
                for (int p = 0; p < NUM_SLOTS; p++) begin
                    cnt_reg[d][p] <= eoe_reg ? '0 : cnt_next[d][p];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proceed && eoe_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proceed && eoe_reg) begin
            trig_reg <= trig_next;
        end
    end

    always_comb begin
        state_busy = fired_reg;
        for (int d = 0; d < NUM_DETECTORS; d++) begin
            if (tot_reg[d] != '0) begin
                state_busy = 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (proceed && eoe_reg) |=> !state_busy)
        else $error("event state not cleared after close");

    a_stall_only_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && eoe_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a blocked close");

    a_result_from_close: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proceed && eoe_reg))
        else $error("result without a closing request");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> (out_valid_reg && $stable(trig_reg)))
        else $error("pending result lost or changed");
`endif

endmodule

`default_nettype wire
